[rtl/core/ssi_pkg.sv]
// Shared types, constants and a helper function for the Simpson sine integrator.
// Used by the datapath, controller and top level; depends on nothing.
package ssi_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int IN_W         = 20;
    localparam int CNT_IN_W     = 11;
    localparam int SPAN_W       = 21;
    localparam int ANG_W        = 36;
    localparam int CW           = 34;
    localparam int ANG_BITS     = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int SRES_W       = 18;
    localparam int STEP_W       = 5;
    localparam int OP_W         = 4;

    localparam logic signed [ANG_W-1:0] TWO_PI_A  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] PI_A      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_A = 36'sd1686629713;
    localparam logic signed [CW-1:0]    GAIN_INV_A = 34'sd652032874;
    localparam logic signed [SRES_W-1:0] SIN_ONE   = 18'sd65536;
    localparam logic signed [SRES_W-1:0] SIN_MONE  = -18'sd65536;
    localparam logic [IN_W-1:0]          OUT_LIMIT = 20'd262144;

    // Datapath operation codes issued by the controller.
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_SDIV  = 4'd2;
    localparam logic [OP_W-1:0] OP_SINIT = 4'd3;
    localparam logic [OP_W-1:0] OP_ANGLE = 4'd4;
    localparam logic [OP_W-1:0] OP_RED   = 4'd5;
    localparam logic [OP_W-1:0] OP_FOLD1 = 4'd6;
    localparam logic [OP_W-1:0] OP_FOLD2 = 4'd7;
    localparam logic [OP_W-1:0] OP_ROT   = 4'd8;
    localparam logic [OP_W-1:0] OP_ACC   = 4'd9;
    localparam logic [OP_W-1:0] OP_MINIT = 4'd10;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd11;
    localparam logic [OP_W-1:0] OP_FDIV  = 4'd12;
    localparam logic [OP_W-1:0] OP_DONE  = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic red_done;
        logic rot_last;
        logic samp_last;
        logic mul_last;
    } t_stat;

    // Arctangent of 2^-j scaled by 2^30; past the table it is 2^(30-j).
    function automatic logic signed [CW-1:0] atan_step(input logic [STEP_W-1:0] j);
        logic [CW-1:0] one;
        one = CW'(1);
        case (j)
            5'd0:    atan_step = 34'sh03243F6A9;
            5'd1:    atan_step = 34'sh01DAC6705;
            5'd2:    atan_step = 34'sh00FADBAFD;
            5'd3:    atan_step = 34'sh007F56EA7;
            5'd4:    atan_step = 34'sh003FEAB77;
            5'd5:    atan_step = 34'sh001FFD55C;
            5'd6:    atan_step = 34'sh000FFFAAB;
            5'd7:    atan_step = 34'sh0007FFF55;
            5'd8:    atan_step = 34'sh0003FFFEB;
            5'd9:    atan_step = 34'sh0001FFFFD;
            5'd10:   atan_step = 34'sh000100000;
            default: atan_step = $signed(one << (6'(ANG_BITS) - {1'b0, j}));
        endcase
    endfunction

endpackage

[rtl/core/simpson_rule_sine_integrator.sv]
// Composite Simpson integrator of sin(x) over [lower_bound, upper_bound] in Q3.16.
// Each request runs the 30-step CORDIC loop of the datapath once for each of its
// 2N+1 sample points, where N is the clamped interval count, and uses the shared
// bit-serial divider for the sample-step and final scaling divisions; the divider's
// dividend width PW is 21 plus the bits of the weighted sum (51 for the default
// MAX_INTERVALS). The result appears on o_integral as o_valid goes high for exactly
// one cycle; the strobe cannot be held off, and busy is low again in that same cycle.
// Depends on ssi_pkg, ssi_ctrl, ssi_datapath and ssi_div.
module simpson_rule_sine_integrator #(
    parameter int MAX_INTERVALS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ssi_pkg::IN_W-1:0]    i_lower_bound,
    input  logic signed [ssi_pkg::IN_W-1:0]    i_upper_bound,
    input  logic [ssi_pkg::CNT_IN_W-1:0]       i_interval_count,
    output logic                               o_valid,
    output logic signed [ssi_pkg::IN_W-1:0]    o_integral
);
    ssi_pkg::t_cmd  cmd;
    ssi_pkg::t_stat stat;

    ssi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    ssi_datapath #(
        .MAX_INTERVALS(MAX_INTERVALS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_lower_bound    (i_lower_bound),
        .i_upper_bound    (i_upper_bound),
        .i_interval_count (i_interval_count),
        .o_stat           (stat),
        .o_integral       (o_integral)
    );

endmodule

[rtl/core/ssi_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Shared by the sample-step and final scaling divisions; uses no package items.
module ssi_div #(
    parameter int DVD_W = 51,
    parameter int DVS_W = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quo,
    output logic [DVS_W-1:0] o_rem,
    output logic             o_done
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_quo = i_dividend;
            n_rem = '0;
            n_cnt = CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            n_quo = {r_quo[DVD_W-2:0], ge};
            n_rem = ge ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

[rtl/core/ssi_datapath.sv]
// Datapath: sample abscissa stepping, angle reduction, CORDIC sine, weighted sum,
// shift-add multiply and final rounding. Uses ssi_pkg and the ssi_div divider.
module ssi_datapath #(
    parameter int MAX_INTERVALS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssi_pkg::t_cmd                       i_cmd,
    input  logic signed [ssi_pkg::IN_W-1:0]     i_lower_bound,
    input  logic signed [ssi_pkg::IN_W-1:0]     i_upper_bound,
    input  logic [ssi_pkg::CNT_IN_W-1:0]        i_interval_count,
    output ssi_pkg::t_stat                      o_stat,
    output logic signed [ssi_pkg::IN_W-1:0]     o_integral
);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int D_W   = CNT_W + 1;
    localparam int ACC_W = $clog2(6 * MAX_INTERVALS + 1) + ssi_pkg::FRAC_BITS + 1;
    localparam int PW    = ssi_pkg::SPAN_W + ACC_W;
    localparam int DEN_W = CNT_W + 3 + ssi_pkg::FRAC_BITS;
    localparam int SH    = ssi_pkg::ANG_BITS - ssi_pkg::FRAC_BITS;
    localparam int X_W   = ssi_pkg::SPAN_W + 1;

    logic signed [ssi_pkg::IN_W-1:0]   r_lo;
    logic                              r_span_neg;
    logic [ssi_pkg::SPAN_W-1:0]        r_span_abs;
    logic [CNT_W-1:0]                  r_cnt;
    logic [ssi_pkg::SPAN_W-1:0]        r_q0;
    logic [D_W-1:0]                    r_r0;
    logic [ssi_pkg::SPAN_W-1:0]        r_acc_q;
    logic [D_W:0]                      r_acc_r;
    logic [D_W:0]                      r_j;
    logic signed [ACC_W-1:0]           r_total;
    logic signed [ssi_pkg::ANG_W-1:0]  r_ang;
    logic signed [ssi_pkg::CW-1:0]     r_cx, r_cy, r_z;
    logic [ssi_pkg::STEP_W-1:0]        r_it;
    logic [PW-1:0]                     r_prod, r_mcand;
    logic [ssi_pkg::SPAN_W-1:0]        r_mq;
    logic [ssi_pkg::STEP_W-1:0]        r_mcnt;
    logic signed [ssi_pkg::IN_W-1:0]   r_out;

    logic signed [ssi_pkg::SPAN_W-1:0] span;
    logic [31:0]                       cnt_ext;
    logic [CNT_W-1:0]                  cnt_clamp;
    logic [D_W-1:0]                    d_val;
    logic [DEN_W-1:0]                  den;
    logic                              div_start;
    logic [PW-1:0]                     div_dvd;
    logic [DEN_W-1:0]                  div_dvs;
    logic [PW-1:0]                     div_quo;
    logic [DEN_W-1:0]                  div_rem;
    logic                              div_done;
    logic signed [X_W-1:0]             x_pos;
    logic signed [ssi_pkg::ANG_W-1:0]  fold1;
    logic signed [ssi_pkg::CW-1:0]     dx, dy, step;
    logic signed [ssi_pkg::CW-1:0]     cy_rnd, cy_sh;
    logic signed [ssi_pkg::SRES_W-1:0] sres;
    logic signed [ACC_W-1:0]           sres_ext, term;
    logic [D_W:0]                      acc_r_sum;
    logic                              tot_neg;
    logic [PW-1:0]                     tot_abs;
    logic [PW:0]                       quo_rnd;
    logic [ssi_pkg::IN_W-1:0]          quo_sat;

    assign span    = ssi_pkg::SPAN_W'(i_upper_bound) - ssi_pkg::SPAN_W'(i_lower_bound);
    assign cnt_ext = 32'(i_interval_count);
    always_comb begin
        if (cnt_ext == 32'd0) begin
            cnt_clamp = CNT_W'(1);
        end else if (cnt_ext > 32'(MAX_INTERVALS)) begin
            cnt_clamp = CNT_W'(MAX_INTERVALS);
        end else begin
            cnt_clamp = CNT_W'(cnt_ext);
        end
    end

    assign d_val = {r_cnt, 1'b0};
    assign den   = {DEN_W'({3'b000, r_cnt} << 2) + DEN_W'({3'b000, r_cnt} << 1)}
                   << ssi_pkg::FRAC_BITS;

    assign div_start = (i_cmd.op == ssi_pkg::OP_SDIV) || (i_cmd.op == ssi_pkg::OP_FDIV);
    assign div_dvd   = (i_cmd.op == ssi_pkg::OP_SDIV) ? PW'(r_span_abs) : r_prod;
    assign div_dvs   = (i_cmd.op == ssi_pkg::OP_SDIV) ? DEN_W'(d_val) : den;

    ssi_div #(
        .DVD_W(PW),
        .DVS_W(DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    // Abscissa of the current sample: lower bound plus the rounded fraction of the span.
    assign x_pos = r_span_neg ? (X_W'(r_lo) - $signed({1'b0, r_acc_q}))
                              : (X_W'(r_lo) + $signed({1'b0, r_acc_q}));

    assign fold1 = (r_ang > ssi_pkg::PI_A) ? r_ang - ssi_pkg::TWO_PI_A : r_ang;

    assign dx   = r_cy >>> r_it;
    assign dy   = r_cx >>> r_it;
    assign step = ssi_pkg::atan_step(r_it);

    assign cy_rnd = r_cy + ssi_pkg::CW'(1 << (SH - 1));
    assign cy_sh  = cy_rnd >>> SH;
    always_comb begin
        if (cy_sh > ssi_pkg::CW'(ssi_pkg::SIN_ONE)) begin
            sres = ssi_pkg::SIN_ONE;
        end else if (cy_sh < ssi_pkg::CW'(ssi_pkg::SIN_MONE)) begin
            sres = ssi_pkg::SIN_MONE;
        end else begin
            sres = ssi_pkg::SRES_W'(cy_sh);
        end
    end
    assign sres_ext = ACC_W'(sres);

    // End samples count once, odd (midpoint) samples four times, shared ends twice.
    always_comb begin
        if ((r_j == '0) || (r_j == {1'b0, d_val})) begin
            term = sres_ext;
        end else if (r_j[0]) begin
            term = sres_ext <<< 2;
        end else begin
            term = sres_ext <<< 1;
        end
    end

    assign acc_r_sum = r_acc_r + {1'b0, r_r0};

    assign tot_neg = r_total[ACC_W-1];
    assign tot_abs = PW'(tot_neg ? -r_total : r_total);

    assign quo_rnd = {1'b0, div_quo} + (PW + 1)'({div_rem, 1'b0} >= {1'b0, den});
    assign quo_sat = (quo_rnd > (PW + 1)'(ssi_pkg::OUT_LIMIT)) ? ssi_pkg::OUT_LIMIT
                                                              : quo_rnd[ssi_pkg::IN_W-1:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ssi_pkg::OP_LOAD: begin
                r_lo       <= i_lower_bound;
                r_span_neg <= span[ssi_pkg::SPAN_W-1];
                r_span_abs <= span[ssi_pkg::SPAN_W-1] ? -span : span;
                r_cnt      <= cnt_clamp;
            end
            ssi_pkg::OP_SINIT: begin
                r_q0    <= div_quo[ssi_pkg::SPAN_W-1:0];
                r_r0    <= div_rem[D_W-1:0];
                r_acc_q <= '0;
                r_acc_r <= (D_W + 1)'(r_cnt);
                r_j     <= '0;
                r_total <= '0;
            end
            ssi_pkg::OP_ANGLE: begin
                r_ang <= ssi_pkg::ANG_W'(x_pos) <<< SH;
            end
            ssi_pkg::OP_RED: begin
                if (r_ang < 0) begin
                    r_ang <= r_ang + ssi_pkg::TWO_PI_A;
                end else if (r_ang >= ssi_pkg::TWO_PI_A) begin
                    r_ang <= r_ang - ssi_pkg::TWO_PI_A;
                end
            end
            ssi_pkg::OP_FOLD1: begin
                r_ang <= fold1;
            end
            ssi_pkg::OP_FOLD2: begin
                if (r_ang > ssi_pkg::HALF_PI_A) begin
                    r_z <= ssi_pkg::CW'(ssi_pkg::PI_A - r_ang);
                end else if (r_ang < -ssi_pkg::HALF_PI_A) begin
                    r_z <= ssi_pkg::CW'(-ssi_pkg::PI_A - r_ang);
                end else begin
                    r_z <= ssi_pkg::CW'(r_ang);
                end
                r_cx <= ssi_pkg::GAIN_INV_A;
                r_cy <= '0;
                r_it <= '0;
            end
            ssi_pkg::OP_ROT: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_z  <= r_z - step;
                end else begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_z  <= r_z + step;
                end
                r_it <= r_it + ssi_pkg::STEP_W'(1);
            end
            ssi_pkg::OP_ACC: begin
                r_total <= r_total + term;
                r_j     <= r_j + (D_W + 1)'(1);
                if (acc_r_sum >= {1'b0, d_val}) begin
                    r_acc_r <= acc_r_sum - {1'b0, d_val};
                    r_acc_q <= r_acc_q + r_q0 + ssi_pkg::SPAN_W'(1);
                end else begin
                    r_acc_r <= acc_r_sum;
                    r_acc_q <= r_acc_q + r_q0;
                end
            end
            ssi_pkg::OP_MINIT: begin
                r_prod  <= '0;
                r_mcand <= tot_abs;
                r_mq    <= r_span_abs;
                r_mcnt  <= '0;
            end
            ssi_pkg::OP_MUL: begin
                if (r_mq[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand <= r_mcand << 1;
                r_mq    <= r_mq >> 1;
                r_mcnt  <= r_mcnt + ssi_pkg::STEP_W'(1);
            end
            ssi_pkg::OP_DONE: begin
                r_out <= (r_span_neg != tot_neg) ? -$signed(quo_sat) : $signed(quo_sat);
            end
            default: begin
            end
        endcase
    end

    assign o_stat.div_done  = div_done;
    assign o_stat.red_done  = (r_ang >= 0) && (r_ang < ssi_pkg::TWO_PI_A);
    assign o_stat.rot_last  = (r_it == ssi_pkg::STEP_W'(ssi_pkg::CORDIC_STEPS - 1));
    assign o_stat.samp_last = (r_j == {1'b0, d_val});
    assign o_stat.mul_last  = (r_mcnt == ssi_pkg::STEP_W'(ssi_pkg::SPAN_W - 1));
    assign o_integral       = r_out;

endmodule

[rtl/core/ssi_ctrl.sv]
// Controller state machine: sequences the datapath through each request.
// Uses ssi_pkg for the command and status types and the operation codes.
module ssi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ssi_pkg::t_stat i_stat,
    output ssi_pkg::t_cmd  o_cmd,
    output logic           busy,
    output logic           o_valid
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SDIV  = 4'd2;
    localparam logic [3:0] S_SWAIT = 4'd3;
    localparam logic [3:0] S_SINIT = 4'd4;
    localparam logic [3:0] S_ANGLE = 4'd5;
    localparam logic [3:0] S_RED   = 4'd6;
    localparam logic [3:0] S_FOLD1 = 4'd7;
    localparam logic [3:0] S_FOLD2 = 4'd8;
    localparam logic [3:0] S_ROT   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_MINIT = 4'd11;
    localparam logic [3:0] S_MUL   = 4'd12;
    localparam logic [3:0] S_FDIV  = 4'd13;
    localparam logic [3:0] S_FWAIT = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_valid;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = ssi_pkg::OP_NOP;
        case (r_state)
            S_IDLE: begin
                // Operands are captured at the accepting edge itself.
                if (start) begin
                    o_cmd.op = ssi_pkg::OP_LOAD;
                    n_state  = S_SDIV;
                end
            end
            S_SDIV: begin
                o_cmd.op = ssi_pkg::OP_SDIV;
                n_state  = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_cmd.op = ssi_pkg::OP_SINIT;
                n_state  = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.op = ssi_pkg::OP_ANGLE;
                n_state  = S_RED;
            end
            S_RED: begin
                if (i_stat.red_done) begin
                    n_state = S_FOLD1;
                end else begin
                    o_cmd.op = ssi_pkg::OP_RED;
                end
            end
            S_FOLD1: begin
                o_cmd.op = ssi_pkg::OP_FOLD1;
                n_state  = S_FOLD2;
            end
            S_FOLD2: begin
                o_cmd.op = ssi_pkg::OP_FOLD2;
                n_state  = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = ssi_pkg::OP_ROT;
                if (i_stat.rot_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = ssi_pkg::OP_ACC;
                n_state  = i_stat.samp_last ? S_MINIT : S_ANGLE;
            end
            S_MINIT: begin
                o_cmd.op = ssi_pkg::OP_MINIT;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = ssi_pkg::OP_MUL;
                if (i_stat.mul_last) begin
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                o_cmd.op = ssi_pkg::OP_FDIV;
                n_state  = S_FWAIT;
            end
            S_FWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.op = ssi_pkg::OP_DONE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_DONE);
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // The strobe follows the rounding cycle and nothing else.
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished request");

    // An accepted request goes straight to the step division.
    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_SDIV))
        else $error("accepted request did not start the step division");

    // A divider completion is only consumed while a division is pending.
    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> ((r_state == S_SWAIT) || (r_state == S_FWAIT)))
        else $error("divider finished outside a wait state");

    // The sine loop never leaves rotation before its last step.
    a_rot_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ROT) && !i_stat.rot_last) |=> (r_state == S_ROT))
        else $error("CORDIC loop left early");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for simpson_rule_sine_integrator.
// Predicts each integral with a CORDIC sine model and compares every transfer.
// Depends on ssi_pkg and the RTL of the integrator.
`timescale 1ns / 100ps

module tb;

    localparam longint ANG_TWO_PI  = 64'sd6746518852;
    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint ANG_GAIN    = 64'sd652032874;
    localparam int     N_MAX       = 1024;
    localparam longint Q16_ONE     = 64'sd65536;
    localparam longint ARCTAN_Q30 [0:10] = '{
        64'h3243F6A9, 64'h1DAC6705, 64'h0FADBAFD, 64'h07F56EA7,
        64'h03FEAB77, 64'h01FFD55C, 64'h00FFFAAB, 64'h007FFF55,
        64'h003FFFEB, 64'h001FFFFD, 64'h00100000
    };

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic signed [ssi_pkg::IN_W-1:0]      i_lower_bound = '0;
    logic signed [ssi_pkg::IN_W-1:0]      i_upper_bound = '0;
    logic [ssi_pkg::CNT_IN_W-1:0]         i_interval_count = '0;
    logic                                 o_valid;
    logic signed [ssi_pkg::IN_W-1:0]      o_integral;

    logic signed [ssi_pkg::IN_W-1:0] expected_integrals [$];
    int mismatches = 0;
    int burst_left = 0;

    simpson_rule_sine_integrator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_lower_bound(i_lower_bound), .i_upper_bound(i_upper_bound),
        .i_interval_count(i_interval_count), .o_valid(o_valid), .o_integral(o_integral)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Round half away from zero; den is positive.
    function automatic longint round_div(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    // Sine of a Q3.16 angle in Q16, via reduction and a 30-step rotation.
    function automatic longint cordic_sine(longint pos);
        longint r, cx, cy, dx, dy, stp, res;
        r = (pos * 16384) % ANG_TWO_PI;
        if (r < 0) r += ANG_TWO_PI;
        if (r > ANG_PI) r -= ANG_TWO_PI;
        if (r > ANG_HALF_PI) r = ANG_PI - r;
        else if (r < -ANG_HALF_PI) r = -ANG_PI - r;
        cx = ANG_GAIN;
        cy = 0;
        for (int j = 0; j < 30; j++) begin
            stp = (j < 11) ? ARCTAN_Q30[j] : (64'sd1 <<< (30 - j));
            dx = cy >>> j;
            dy = cx >>> j;
            if (r >= 0) begin
                cx -= dx; cy += dy; r -= stp;
            end else begin
                cx += dx; cy -= dy; r += stp;
            end
        end
        res = (cy + 8192) >>> 14;
        if (res > Q16_ONE) res = Q16_ONE;
        if (res < -Q16_ONE) res = -Q16_ONE;
        return res;
    endfunction

    function automatic logic signed [ssi_pkg::IN_W-1:0] simpson_integral(
        logic signed [ssi_pkg::IN_W-1:0] lo, logic signed [ssi_pkg::IN_W-1:0] hi,
        logic [ssi_pkg::CNT_IN_W-1:0] n_raw);
        longint a, span, cnt, total, mag, den;
        a = lo;
        span = longint'(hi) - a;
        cnt = n_raw;
        total = 0;
        if (cnt < 1) cnt = 1;
        if (cnt > N_MAX) cnt = N_MAX;
        for (longint k = 0; k < cnt; k++) begin
            total += cordic_sine(a + round_div(2 * k * span, 2 * cnt))
                   + cordic_sine(a + round_div((2 * k + 2) * span, 2 * cnt))
                   + 4 * cordic_sine(a + round_div((2 * k + 1) * span, 2 * cnt));
        end
        // The product stays below 2^55, so 64 bits hold it exactly.
        mag = ((span < 0) ? -span : span) * ((total < 0) ? -total : total);
        den = 6 * cnt * Q16_ONE;
        mag = (mag + den / 2) / den;
        if (mag > 262144) mag = 262144;
        if ((span < 0) != (total < 0)) mag = -mag;
        return ssi_pkg::IN_W'(mag);
    endfunction

    // Sends one request; requests go out in random bursts with random idle gaps between.
    task automatic send_request(logic signed [ssi_pkg::IN_W-1:0] lo,
                                logic signed [ssi_pkg::IN_W-1:0] hi,
                                logic [ssi_pkg::CNT_IN_W-1:0] n);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_lower_bound <= lo;
        i_upper_bound <= hi;
        i_interval_count <= n;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_integrals.push_back(simpson_integral(lo, hi, n));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_integrals.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_field_extremes();
        send_request(20'sh00000, 20'sh10000, 11'd1);
        send_request(-20'sd262144, 20'sd262144, 11'd4);
        send_request(20'sd262144, -20'sd262144, 11'd3);
        send_request(20'sh80000, 20'sh7FFFF, 11'd2);
        send_request(20'sh7FFFF, 20'sh80000, 11'd1);
        send_request(20'sd0, 20'sd205887, 11'd1024);
        send_request(20'sd1, -20'sd1, 11'd5);
    endtask

    task automatic test_special_cases();
        send_request(20'sd0, 20'sd102943, 11'd0);       // zero count acts as one
        send_request(-20'sd102943, 20'sd0, 11'd2047);   // count clamps to the maximum
        send_request(20'sd54321, 20'sd54321, 11'd7);    // equal bounds
        send_request(20'sd205887, 20'sd0, 11'd6);       // reversed bounds
        send_request(20'sh80000, 20'sd318505, 11'd1);   // coarse estimate saturates
        send_request(20'sd318505, 20'sh80000, 11'd1);
        send_request(20'sh6_0000, -20'sh6_0000, 11'd9); // bounds beyond +/-4
        drain_results();
    endtask

    task automatic test_random_requests();
        logic signed [ssi_pkg::IN_W-1:0] lo, hi;
        logic [ssi_pkg::CNT_IN_W-1:0] n;
        for (int i = 0; i < 100; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                lo = ssi_pkg::IN_W'($urandom);
                hi = ssi_pkg::IN_W'($urandom);
            end else begin
                lo = ssi_pkg::IN_W'(int'($urandom_range(0, 524288)) - 262144);
                hi = ssi_pkg::IN_W'(int'($urandom_range(0, 524288)) - 262144);
            end
            case ($urandom_range(0, 19))
                0:       n = 11'($urandom_range(1025, 2047));
                1:       n = 11'($urandom_range(64, 1024));
                2:       n = '0;
                default: n = 11'($urandom_range(1, 12));
            endcase
            send_request(lo, hi, n);
            if (i == 50) drain_results();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_integrals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: integral=%0d", o_integral);
            end else begin
                if (o_integral !== expected_integrals[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("integral mismatch: expected %0d, got %0d",
                                 expected_integrals[0], o_integral);
                end
                void'(expected_integrals.pop_front());
            end
        end
    end

    initial begin
        #600_000_000;
        $display("simpson_rule_sine_integrator regression: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_special_cases();
        test_random_requests();
        drain_results();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_integrals.size() == 0) begin
            $display("simpson_rule_sine_integrator regression: pass");
        end else begin
            $display("simpson_rule_sine_integrator regression: fail");
        end
        $finish;
    end

endmodule
